@@ hw/rtl/hra_pkg.sv @@
// ============================================================================
// hra_pkg: shared types and constants of the heart rate averager
// Holds the payload structs, the controller states, the command and status
// groups between the controller and the datapath, and the fixed constants.
// ============================================================================
package hra_pkg;

    // Ring of accepted rates. The mean is taken by a shift, so the depth
    // is kept a power of two.
    localparam int RING_DEPTH = 8;
    localparam int RING_BITS  = $clog2(RING_DEPTH);
    localparam int SUM_W      = 8 + RING_BITS;

    // Beats per minute from a millisecond interval: 60 * 1000.
    localparam int RATE_NUM_W = 16;
    localparam logic [RATE_NUM_W-1:0] RATE_NUMERATOR = 16'd60000;
    localparam logic [15:0] DIV_STEPS_LAST = 16'd15;

    localparam logic [17:0] IR_RESET      = 18'd50000;
    localparam logic [7:0]  FLOOR_RESET   = 8'd20;
    localparam logic [8:0]  CEILING_RESET = 9'd255;
    localparam logic [7:0]  RATE_MAX      = 8'd255;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IR_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_FLOOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_CEILING = 2'd2;
    localparam int CFG_DATA_W = 18;

    typedef struct packed {
        logic [17:0] ir_level;
        logic        beat_flag;
        logic [31:0] time_ms;
    } t_hra_in;

    typedef struct packed {
        logic       signal_present;
        logic       beat_taken;
        logic [7:0] rate_average;
    } t_hra_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MULT,
        ST_TEST,
        ST_DIV,
        ST_STORE,
        ST_AVG,
        ST_FINISH
    } t_hra_state;

    typedef struct packed {
        logic capture;
        logic evaluate;
        logic multiply;
        logic div_start;
        logic div_step;
        logic store;
        logic average;
        logic emit;
    } t_hra_cmd;

    typedef struct packed {
        logic beat_valid;
        logic rate_ok;
        logic div_last;
        logic out_free;
    } t_hra_status;

endpackage

@@ hw/rtl/hra_ctrl.sv @@
// ============================================================================
// hra_ctrl: sequencing controller of the heart rate averager
// Steps one item through evaluation, range test, division and ring update.
// ============================================================================
module hra_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  hra_pkg::t_hra_status i_status,
    output logic                o_in_stall,
    output hra_pkg::t_hra_cmd   o_cmd
);

    hra_pkg::t_hra_state r_state;
    hra_pkg::t_hra_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hra_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hra_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = hra_pkg::ST_EVAL;
                end
            end
            hra_pkg::ST_EVAL: begin
                n_state = i_status.beat_valid ? hra_pkg::ST_MULT : hra_pkg::ST_FINISH;
            end
            hra_pkg::ST_MULT:  n_state = hra_pkg::ST_TEST;
            hra_pkg::ST_TEST: begin
                n_state = i_status.rate_ok ? hra_pkg::ST_DIV : hra_pkg::ST_FINISH;
            end
            hra_pkg::ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = hra_pkg::ST_STORE;
                end
            end
            hra_pkg::ST_STORE: n_state = hra_pkg::ST_AVG;
            hra_pkg::ST_AVG:   n_state = hra_pkg::ST_FINISH;
            hra_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = hra_pkg::ST_IDLE;
                end
            end
            default: n_state = hra_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            hra_pkg::ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            hra_pkg::ST_EVAL:  o_cmd.evaluate = 1'b1;
            hra_pkg::ST_MULT:  o_cmd.multiply = 1'b1;
            hra_pkg::ST_TEST:  o_cmd.div_start = i_status.rate_ok;
            hra_pkg::ST_DIV:   o_cmd.div_step = 1'b1;
            hra_pkg::ST_STORE: o_cmd.store = 1'b1;
            hra_pkg::ST_AVG:   o_cmd.average = 1'b1;
            hra_pkg::ST_FINISH: o_cmd.emit = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ hw/rtl/hra_datapath.sv @@
// ============================================================================
// hra_datapath: registers and arithmetic of the heart rate averager
// Configuration, beat timing, range test, restoring divider, rate ring with
// running sum, and the output register.
// ============================================================================
module hra_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hra_pkg::t_hra_cmd                 i_cmd,
    input  hra_pkg::t_hra_in                  i_in_data,
    input  logic                              i_cfg_valid,
    input  logic [hra_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hra_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_out_stall,
    output hra_pkg::t_hra_status              o_status,
    output logic                              o_out_valid,
    output hra_pkg::t_hra_out                 o_out_data
);

    logic [17:0] r_ir_threshold;
    logic [7:0]  r_rate_floor;
    logic [8:0]  r_rate_ceiling;

    hra_pkg::t_hra_in r_item;
    logic        r_present;
    logic        r_taken;
    logic [31:0] r_last_beat;
    logic [31:0] r_interval;
    logic [40:0] r_prod_ceil;
    logic [39:0] r_prod_floor;

    logic [15:0] r_rem;
    logic [15:0] r_quo;
    logic [3:0]  r_div_cnt;

    logic [7:0]  r_ring [hra_pkg::RING_DEPTH];
    logic [hra_pkg::RING_BITS-1:0] r_slot;
    logic [hra_pkg::SUM_W-1:0]     r_ring_sum;
    logic [7:0]  r_held;

    logic        r_out_valid;
    hra_pkg::t_hra_out r_out_data;

    logic        present;
    logic [16:0] trial;
    logic        trial_fits;
    logic [7:0]  rate_sat;

    assign present    = r_item.ir_level >= r_ir_threshold;
    assign trial      = {r_rem, r_quo[15]};
    assign trial_fits = {15'd0, trial} >= r_interval;
    assign rate_sat   = (r_quo > {8'd0, hra_pkg::RATE_MAX}) ? hra_pkg::RATE_MAX : r_quo[7:0];

    assign o_status.beat_valid = present && r_item.beat_flag;
    // Exact test of floor < 60000 / interval < ceiling without a division.
    assign o_status.rate_ok    = ({25'd0, hra_pkg::RATE_NUMERATOR} < r_prod_ceil) &&
                                 ({24'd0, hra_pkg::RATE_NUMERATOR} > r_prod_floor);
    assign o_status.div_last   = r_div_cnt == hra_pkg::DIV_STEPS_LAST[3:0];
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ir_threshold <= hra_pkg::IR_RESET;
            r_rate_floor   <= hra_pkg::FLOOR_RESET;
            r_rate_ceiling <= hra_pkg::CEILING_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hra_pkg::CFG_IR_THRESHOLD: r_ir_threshold <= i_cfg_data;
                hra_pkg::CFG_RATE_FLOOR:   r_rate_floor   <= i_cfg_data[7:0];
                hra_pkg::CFG_RATE_CEILING: r_rate_ceiling <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Item capture and beat timing.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.evaluate) begin
            r_present  <= present;
            r_taken    <= present && r_item.beat_flag;
            r_interval <= r_item.time_ms - r_last_beat;
        end
        if (i_cmd.multiply) begin
            r_prod_ceil  <= r_rate_ceiling * r_interval;
            r_prod_floor <= r_rate_floor * r_interval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_beat <= '0;
        end else if (i_cmd.evaluate && present && r_item.beat_flag) begin
            r_last_beat <= r_item.time_ms;
        end
    end

    // Restoring divider, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem     <= '0;
            r_quo     <= hra_pkg::RATE_NUMERATOR;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= trial_fits ? 16'(trial - r_interval[16:0]) : trial[15:0];
            r_quo     <= {r_quo[14:0], trial_fits};
            r_div_cnt <= r_div_cnt + 4'd1;
        end
    end

    // Rate ring with a running sum; the mean is a shift of the sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < hra_pkg::RING_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
            r_slot     <= '0;
            r_ring_sum <= '0;
            r_held     <= '0;
        end else begin
            if (i_cmd.store) begin
                r_ring[r_slot] <= rate_sat;
                r_ring_sum     <= r_ring_sum - {{hra_pkg::RING_BITS{1'b0}}, r_ring[r_slot]}
                                  + {{hra_pkg::RING_BITS{1'b0}}, rate_sat};
                r_slot         <= r_slot + 1'b1;
            end
            if (i_cmd.average) begin
                r_held <= r_ring_sum[hra_pkg::SUM_W-1:hra_pkg::RING_BITS];
            end else if (i_cmd.evaluate && !present) begin
                r_held <= '0;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data.signal_present <= r_present;
            r_out_data.beat_taken     <= r_taken;
            r_out_data.rate_average   <= r_present ? r_held : 8'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ hw/rtl/heart_rate_averager_core.sv @@
// ============================================================================
// heart_rate_averager_core: pulse rate averaging over a ring of beat rates
// Top level joining the sequencing controller and the arithmetic datapath.
// ============================================================================
// Usage:
// Each input transfer carries an infrared sample, a beat flag and a
// millisecond timestamp; every input transfer yields exactly one output
// transfer with the signal flag, the beat flag as taken and the averaged
// rate in beats per minute.
// The block works on one item at a time. An item without an accepted beat
// and a beat that fails the range test skip the division; an item whose beat
// passes the range test goes through the 16-step restoring divider that
// turns the beat interval into a rate.
// The result sits in an output register, so a stalled receiver does not
// block the next input until a second result is ready to be loaded.
// Synchronous active-low reset restores the three configuration registers
// to their defaults, clears the beat time, the rate ring and the average,
// and drops the output valid.
// Configuration writes are always ready and should be made while idle.
// ============================================================================
module heart_rate_averager_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  hra_pkg::t_hra_in               i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output hra_pkg::t_hra_out              o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hra_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    hra_pkg::t_hra_cmd    cmd;
    hra_pkg::t_hra_status status;

    // Register writes go straight into the registers, so the port never waits.
    assign o_cfg_ready = 1'b1;

    // The controller owns sequencing and the input stall.
    hra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // The datapath holds all item state and drives the output channel.
    hra_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
